>>> sv/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int HALF_W      = 64;
  localparam int STAMP_W     = 32;
  localparam int DIGITS      = STAMP_W / 4;

  // byte n of a 16-byte block sits at bits 8n+7..8n
  typedef logic [KEY_BYTES-1:0][7:0] byte_vec_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VERIFY_LOW  = 3'd0,
    REG_VERIFY_HIGH = 3'd1,
    REG_DATE_STAMP  = 3'd2,
    REG_TIME_STAMP  = 3'd3
  } cfg_reg_t;

  // everything the datapath takes from the register file
  typedef struct packed {
    byte_vec_t target;  // needle xor verification bytes
  } cfg_view_t;

  localparam byte_vec_t BASE_KEY = {
    8'hba, 8'h3f, 8'h23, 8'h98, 8'h84, 8'he3, 8'h7e, 8'hd5,
    8'h44, 8'h4d, 8'h12, 8'h38, 8'h05, 8'h43, 8'h9e, 8'hab
  };

  // first pass runs under a fixed key, so its keystream is a constant
  function automatic byte_vec_t pass1_mask();
    byte_vec_t  k;
    byte_vec_t  m;
    logic [7:0] mix;
    logic [7:0] nb;
    k = BASE_KEY;
    m = '0;
    for (int n = 0; n < KEY_BYTES; n++) begin
      mix = 8'(32'(k[0]) * n);
      nb  = (n + 1 < KEY_BYTES) ? k[n+1] : k[0];
      m[n] = k[n] ^ mix;
      k[n] = k[n] + nb;
      if (k[n] == 8'd0) begin
        k[n] = 8'd1;
      end
    end
    return m;
  endfunction

  localparam byte_vec_t PASS1_MASK = pass1_mask();

  // lowercase ascii hex digit
  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h57 + {4'd0, v};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/document_password_check_core.sv
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   in_candidate_low, in_candidate_high
// out_      output     out_valid / out_ready out_match
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high
// stages: key (first pass + key byte 0 update), mix (per-byte multiply
// and compare), output (and-reduce into the output register)
// synchronous active-low reset clears stage valids and the config registers
// a stall holds each stage; ready ripples back only through full stages
// cfg_ready is always high; the user must write registers only while idle (not enforced)

module document_password_check_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dpc_pkg::HALF_W-1:0]      in_candidate_low,
  input  wire logic [dpc_pkg::HALF_W-1:0]      in_candidate_high,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_match,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dpc_pkg::*;

  cfg_view_t            cfg_view;
  logic                 s1_valid;
  logic                 s1_ready;
  byte_vec_t            s1_diff;
  logic [7:0]           s1_step;
  logic                 s2_valid;
  logic                 s2_ready;
  logic [KEY_BYTES-1:0] s2_eq;
  logic                 out_valid_r;
  logic                 out_match_r;

  assign cfg_ready = 1'b1;

  // verification bytes and needle, folded into one target per byte
  dpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_view (cfg_view)
  );

  // stage 1: working key, updated key byte 0, byte differences
  dpc_key_stage u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cand_low  (in_candidate_low),
    .cand_high (in_candidate_high),
    .cfg_view  (cfg_view),
    .dn_valid  (s1_valid),
    .dn_ready  (s1_ready),
    .dn_diff   (s1_diff),
    .dn_step   (s1_step)
  );

  // stage 2: second-pass keystream mix and per-byte compare
  dpc_mix_stage u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_diff  (s1_diff),
    .up_step  (s1_step),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_eq    (s2_eq)
  );

  // stage 3: output register, all sixteen bytes must agree
  assign s2_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      out_match_r <= &s2_eq;
    end
  end

  assign out_valid = out_valid_r;
  assign out_match = out_match_r;

  // an accepted item reaches out_valid when the sink does not stall
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item lost in pipeline");

  // a free-running sink never backs up the input
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with sink ready");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_valid && !s2_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> sv/dpc_cfg.sv
`default_nettype none

module dpc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [dpc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0]  wr_data,
  output dpc_pkg::cfg_view_t                  cfg_view
);
  import dpc_pkg::*;

  logic [HALF_W-1:0]  verify_low_r;
  logic [HALF_W-1:0]  verify_high_r;
  logic [STAMP_W-1:0] date_stamp_r;
  logic [STAMP_W-1:0] time_stamp_r;
  byte_vec_t          needle;
  byte_vec_t          verify;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verify_low_r  <= '0;
      verify_high_r <= '0;
      date_stamp_r  <= '0;
      time_stamp_r  <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_VERIFY_LOW:  verify_low_r  <= wr_data;
        REG_VERIFY_HIGH: verify_high_r <= wr_data;
        REG_DATE_STAMP:  date_stamp_r  <= wr_data[STAMP_W-1:0];
        REG_TIME_STAMP:  time_stamp_r  <= wr_data[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // needle: date then time, most significant digit first
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      needle[i]          = hex_char(date_stamp_r[STAMP_W-1-4*i -: 4]);
      needle[DIGITS + i] = hex_char(time_stamp_r[STAMP_W-1-4*i -: 4]);
    end
  end

  assign verify          = {verify_high_r, verify_low_r};
  assign cfg_view.target = needle ^ verify;

endmodule

`default_nettype wire

>>> sv/dpc_key_stage.sv
`default_nettype none

module dpc_key_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [dpc_pkg::HALF_W-1:0] cand_low,
  input  wire logic [dpc_pkg::HALF_W-1:0] cand_high,
  input  wire dpc_pkg::cfg_view_t         cfg_view,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output dpc_pkg::byte_vec_t              dn_diff,
  output logic [7:0]                      dn_step
);
  import dpc_pkg::*;

  logic       valid_r;
  byte_vec_t  diff_r;
  byte_vec_t  diff_nxt;
  logic [7:0] step_r;
  logic [7:0] step_nxt;
  byte_vec_t  work_key;
  logic [7:0] sum01;

  // working key is the first-pass output
  assign work_key = {cand_high, cand_low} ^ PASS1_MASK;
  // key byte 0 after its first update, zero forced to one
  assign sum01    = work_key[0] + work_key[1];
  assign step_nxt = (sum01 == 8'd0) ? 8'd1 : sum01;
  assign diff_nxt = work_key ^ cfg_view.target;

  assign in_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      diff_r <= diff_nxt;
      step_r <= step_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_diff  = diff_r;
  assign dn_step  = step_r;

endmodule

`default_nettype wire

>>> sv/dpc_mix_stage.sv
`default_nettype none

module dpc_mix_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire dpc_pkg::byte_vec_t            up_diff,
  input  wire logic [7:0]                    up_step,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output logic [dpc_pkg::KEY_BYTES-1:0]      dn_eq
);
  import dpc_pkg::*;

  logic                 valid_r;
  logic [KEY_BYTES-1:0] eq_r;
  logic [KEY_BYTES-1:0] eq_nxt;
  byte_vec_t            mix;

  // position n mixes in low8(key0 * n); constant n, so shift and add
  always_comb begin
    for (int n = 0; n < KEY_BYTES; n++) begin
      mix[n]    = up_step * 8'(n);
      eq_nxt[n] = (up_diff[n] == mix[n]);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      eq_r <= eq_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_eq    = eq_r;

endmodule

`default_nettype wire
